// ===== hw/rtl/jts_pkg.sv =====
package jts_pkg;

  // Number of vectoring cells in the arctangent chain (8 to 24).
  localparam int ANGLE_STAGES = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STAGE_W      = $clog2(TABLE_LEN);

  // Scaled coordinates: |v| <= 128 * sqrt(2) * 1.65 * 2^16 stays below 2^26.
  localparam int XY_W = 27;
  // Angle accumulator in 2^-16 degree; its magnitude stays below 2^24.
  localparam int Z_W  = 26;

  localparam int ANG_W         = 16;
  localparam int HALF_TURN_Q8  = 46080;
  localparam int QUARTER_Q16   = 90 * 65536;
  localparam int ROUND_Q16     = 128;
  localparam int PULSE_W       = 12;
  localparam int PULSE_MAX     = 4095;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE_SQ = 3'd0,
    REG_CENTER_PULSE = 3'd1,
    REG_GAIN_Q8      = 3'd2,
    REG_STOP_PULSE_0 = 3'd3,
    REG_STOP_PULSE_1 = 3'd4,
    REG_STOP_PULSE_2 = 3'd5,
    REG_STOP_PULSE_3 = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [7:0] joy_x;
    logic [7:0] joy_y;
  } in_word_t;

  typedef struct packed {
    logic               moving;
    logic [PULSE_W-1:0] pulse_0;
    logic [PULSE_W-1:0] pulse_1;
    logic [PULSE_W-1:0] pulse_2;
    logic [PULSE_W-1:0] pulse_3;
  } out_word_t;

  typedef struct packed {
    logic [15:0]             dead_zone_sq;
    logic [PULSE_W-1:0]      center_pulse_us;
    logic [15:0]             gain_q8;
    logic [3:0][PULSE_W-1:0] stop_pulse;
  } cfg_t;

  // Work carried from one cell to the next.
  typedef struct packed {
    logic                  moving;
    logic                  flat;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cell_t;

  // atan(2^-i) in units of 2^-16 degree.
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [STAGE_W-1:0] i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      5'd0:  a = Z_W'(2949120);
      5'd1:  a = Z_W'(1740967);
      5'd2:  a = Z_W'(919879);
      5'd3:  a = Z_W'(466945);
      5'd4:  a = Z_W'(234379);
      5'd5:  a = Z_W'(117305);
      5'd6:  a = Z_W'(58666);
      5'd7:  a = Z_W'(29335);
      5'd8:  a = Z_W'(14668);
      5'd9:  a = Z_W'(7334);
      5'd10: a = Z_W'(3667);
      5'd11: a = Z_W'(1833);
      5'd12: a = Z_W'(917);
      5'd13: a = Z_W'(458);
      5'd14: a = Z_W'(229);
      5'd15: a = Z_W'(115);
      5'd16: a = Z_W'(57);
      5'd17: a = Z_W'(29);
      5'd18: a = Z_W'(14);
      5'd19: a = Z_W'(7);
      5'd20: a = Z_W'(4);
      5'd21: a = Z_W'(2);
      5'd22: a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/jts_front.sv =====
module jts_front
  import jts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_vld,
  input  in_word_t in_word,
  input  logic [15:0] dead_zone_sq,
  output logic     out_vld,
  output cell_t    out_cell
);

  logic signed [7:0]  dx, dy;
  logic signed [15:0] sqx, sqy;
  logic        [16:0] sq;
  logic signed [8:0]  fx, fy;
  logic signed [XY_W-1:0] sx, sy;
  cell_t cell_next;

  always_comb begin
    // Flipping the top bit centres an unsigned byte on 128.
    dx  = signed'(in_word.joy_x ^ 8'h80);
    dy  = signed'(in_word.joy_y ^ 8'h80);
    sqx = dx * dx;
    sqy = dy * dy;
    sq  = {1'b0, unsigned'(sqx)} + {1'b0, unsigned'(sqy)};

    // Turning by half a circle leaves the folded angle unchanged.
    if (dy < 0) begin
      fx = -{dx[7], dx};
      fy = -{dy[7], dy};
    end else begin
      fx = {dx[7], dx};
      fy = {dy[7], dy};
    end
    sx = XY_W'(fx) <<< 16;
    sy = XY_W'(fy) <<< 16;

    cell_next.moving = sq > {1'b0, dead_zone_sq};
    cell_next.flat   = (dy == 8'sd0);
    if (sx < 0) begin
      cell_next.x = sy;
      cell_next.y = -sx;
      cell_next.z = Z_W'(QUARTER_Q16);
    end else begin
      cell_next.x = sx;
      cell_next.y = sy;
      cell_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cell <= cell_next;
    end
  end

endmodule

// ===== hw/rtl/jts_cordic_cell.sv =====
module jts_cordic_cell
  import jts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [STAGE_W-1:0] stage,
  input  logic               in_vld,
  input  cell_t              in_cell,
  output logic               out_vld,
  output cell_t              out_cell
);

  logic signed [XY_W-1:0] xs, ys;
  cell_t cell_next;

  always_comb begin
    xs = in_cell.x >>> stage;
    ys = in_cell.y >>> stage;
    cell_next = in_cell;
    if (!in_cell.y[XY_W-1]) begin
      cell_next.x = in_cell.x + ys;
      cell_next.y = in_cell.y - xs;
      cell_next.z = in_cell.z + atan_q16(stage);
    end else begin
      cell_next.x = in_cell.x - ys;
      cell_next.y = in_cell.y + xs;
      cell_next.z = in_cell.z - atan_q16(stage);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cell <= cell_next;
    end
  end

endmodule

// ===== hw/rtl/jts_back.sv =====
module jts_back
  import jts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  cfg_t      cfg,
  input  logic      in_vld,
  input  cell_t     in_cell,
  output logic      out_vld,
  output out_word_t out_word
);

  logic signed [Z_W-1:0] zr;
  logic signed [Z_W-1:0] zw;
  logic [ANG_W-1:0]      ang_next;
  logic [ANG_W-1:0]      ang;
  logic                  ang_vld, ang_moving;
  logic [31:0]           prod;
  logic                  prod_vld, prod_moving;
  logic [16:0]           sum;
  logic [PULSE_W-1:0]    pulse;
  out_word_t             word_next;

  always_comb begin
    zr = (in_cell.z + Z_W'(ROUND_Q16)) >>> 8;
    if (zr < 0) begin
      zw = zr + Z_W'(HALF_TURN_Q8);
    end else if (zr >= Z_W'(HALF_TURN_Q8)) begin
      zw = zr - Z_W'(HALF_TURN_Q8);
    end else begin
      zw = zr;
    end
    ang_next = in_cell.flat ? '0 : zw[ANG_W-1:0];
  end

  always_comb begin
    sum   = {5'b0, cfg.center_pulse_us} + {1'b0, prod[31:16]};
    pulse = (sum > 17'(PULSE_MAX)) ? PULSE_W'(PULSE_MAX) : sum[PULSE_W-1:0];
    word_next.moving = prod_moving;
    if (prod_moving) begin
      word_next.pulse_0 = pulse;
      word_next.pulse_1 = pulse;
      word_next.pulse_2 = pulse;
      word_next.pulse_3 = pulse;
    end else begin
      word_next.pulse_0 = cfg.stop_pulse[0];
      word_next.pulse_1 = cfg.stop_pulse[1];
      word_next.pulse_2 = cfg.stop_pulse[2];
      word_next.pulse_3 = cfg.stop_pulse[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_vld  <= 1'b0;
      prod_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else if (en) begin
      ang_vld  <= in_vld;
      prod_vld <= ang_vld;
      out_vld  <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang         <= ang_next;
      ang_moving  <= in_cell.moving;
      prod        <= ang * cfg.gain_q8;
      prod_moving <= ang_moving;
      out_word    <= word_next;
    end
  end

endmodule

// ===== hw/rtl/joystick_to_servo_steering.sv =====
// Joystick to servo steering. Each input word carries one joystick sample (two bytes centred
// on 128) and yields exactly one output word: either the four individual stop pulse widths,
// when the squared deflection is at or below dead_zone_sq, or one common pulse width for all
// four servos derived from the stick direction folded into 0 to 180 degrees. A new sample is
// accepted in every cycle in which the output register is empty or being emptied, so the
// sustained rate is one word per clock while out_ready stays high. A sample passes through
// ANGLE_STAGES + 4 registers: one front stage, one cell per arctangent iteration, and three
// stages for rounding, the gain multiply and the final saturate. The first of them is loaded
// at the accepting edge and the last one offers the result. The whole pipeline stalls
// together while a result waits on out_ready.
// Configuration registers are written through the cfg port, which is always ready; writes
// should only be made while the block is idle, since words in flight read the registers as
// they pass. Writes to unknown indices are ignored.
module joystick_to_servo_steering
  import jts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  en;
  logic  vld_chain  [0:ANGLE_STAGES];
  cell_t cell_chain [0:ANGLE_STAGES];

  // The pipeline advances as a whole whenever the output register can take a word.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Register file. Only the low bits of each write that fit the register are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone_sq    <= '0;
      cfg.center_pulse_us <= PULSE_W'(1500);
      cfg.gain_q8         <= 16'd2560;
      cfg.stop_pulse      <= {4{PULSE_W'(1500)}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEAD_ZONE_SQ: cfg.dead_zone_sq    <= cfg_data;
        REG_CENTER_PULSE: cfg.center_pulse_us <= cfg_data[PULSE_W-1:0];
        REG_GAIN_Q8:      cfg.gain_q8         <= cfg_data;
        REG_STOP_PULSE_0: cfg.stop_pulse[0]   <= cfg_data[PULSE_W-1:0];
        REG_STOP_PULSE_1: cfg.stop_pulse[1]   <= cfg_data[PULSE_W-1:0];
        REG_STOP_PULSE_2: cfg.stop_pulse[2]   <= cfg_data[PULSE_W-1:0];
        REG_STOP_PULSE_3: cfg.stop_pulse[3]   <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Centring, dead-zone test, the fold into the upper half plane and the left-half turn.
  jts_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_vld       (in_valid),
    .in_word      (in_data),
    .dead_zone_sq (cfg.dead_zone_sq),
    .out_vld      (vld_chain[0]),
    .out_cell     (cell_chain[0])
  );

  // One vectoring iteration per cell; each cell hands its vector and angle on whenever the pipeline advances.
  for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cell
    jts_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .stage    (STAGE_W'(g)),
      .in_vld   (vld_chain[g]),
      .in_cell  (cell_chain[g]),
      .out_vld  (vld_chain[g+1]),
      .out_cell (cell_chain[g+1])
    );
  end

  // Rounding to 2^-8 degree, the gain multiply, the saturate and the output register.
  jts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_vld   (vld_chain[ANGLE_STAGES]),
    .in_cell  (cell_chain[ANGLE_STAGES]),
    .out_vld  (out_valid),
    .out_word (out_data)
  );

endmodule

// ===== hw/rtl/jts_checker.sv =====
module jts_checker
  import jts_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data,
  input logic      cfg_ready
);

  // A word offered but not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // An empty output register never blocks the input.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  // While moving, all four servos get the same pulse width.
  a_common_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.moving |->
      out_data.pulse_0 == out_data.pulse_1 && out_data.pulse_1 == out_data.pulse_2 &&
      out_data.pulse_2 == out_data.pulse_3)
    else $error("pulse widths differ while moving");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind joystick_to_servo_steering jts_checker u_jts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jts_pkg::*;

  // Cycles from acceptance to the result being offered, with a little margin on top.
  localparam int DRAIN_CYCLES = ANGLE_STAGES + 8;
  // Cycles in a row with no word moving on any channel before the run is abandoned.
  // The longest deliberate quiet stretch is the receiver hold-off below.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int WORDS_PER_PHASE = 90;
  localparam int RANDOM_PHASES = 8;

  // Angle arithmetic: degrees scaled by 2^16 inside the vectoring loop, 2^8 afterwards.
  localparam longint DEG_Q16 = 65536;
  localparam longint QUARTER_TURN_Q16 = 90 * 65536;
  localparam longint HALF_TURN_DEG_Q8 = 46080;
  localparam longint PULSE_CEILING = 4095;
  localparam int ATAN_ENTRIES = 24;

  // An index that names no register; writes to it must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // atan(2^-i) in units of 2^-16 degree.
  localparam longint ATAN_Q16 [0:ATAN_ENTRIES-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  joystick_to_servo_steering uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the register file, updated as each register write is accepted.
  cfg_t steer_cfg;

  // Joystick words waiting to be offered, and the servo words predicted for every
  // joystick word the block has taken but not yet answered.
  in_word_t  joystick_queue[$];
  out_word_t expected_words[$];

  // Knobs that the stimulus sequence turns; all of them are changed on the falling edge,
  // so the clocked processes that read them never race with the change.
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_input = 1'b0;
  int hold_off_requests = 0;

  // Bookkeeping.
  int mismatches = 0;
  int words_checked = 0;
  int steering_words = 0;
  int dead_zone_words = 0;
  int ceiling_words = 0;
  int setting_sets = 1;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predicts the servo word for one joystick sample under the given settings. Outside the
  // dead zone the stick direction is folded into half a turn with a shift-and-add
  // vectoring loop, then turned into a common pulse width for all four servos.
  function automatic out_word_t steer_predict(input in_word_t w, input cfg_t c);
    longint dx, dy, x, y, z, t, xs, ys, angle, pulse;
    int i;
    out_word_t r;
    dx = longint'(w.joy_x) - 128;
    dy = longint'(w.joy_y) - 128;
    if (dx * dx + dy * dy <= longint'(c.dead_zone_sq)) begin
      r.moving  = 1'b0;
      r.pulse_0 = c.stop_pulse[0];
      r.pulse_1 = c.stop_pulse[1];
      r.pulse_2 = c.stop_pulse[2];
      r.pulse_3 = c.stop_pulse[3];
      return r;
    end
    // Pointing into the lower half is turned round by half a turn, which leaves the
    // folded angle as it is. A flat stick (this includes a centred one) reads as zero.
    x = dx;
    y = dy;
    z = 0;
    angle = 0;
    if (y < 0) begin
      x = -x;
      y = -y;
    end
    if (y != 0) begin
      x = x * DEG_Q16;
      y = y * DEG_Q16;
      // Left half: rotate by a quarter turn first so the loop starts near its axis.
      if (x < 0) begin
        t = x;
        x = y;
        y = -t;
        z = QUARTER_TURN_Q16;
      end
      for (i = 0; i < ANGLE_STAGES && i < ATAN_ENTRIES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_Q16[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_Q16[i];
        end
      end
      angle = (z + 128) >>> 8;
      if (angle < 0) begin
        angle = angle + HALF_TURN_DEG_Q8;
      end else if (angle >= HALF_TURN_DEG_Q8) begin
        angle = angle - HALF_TURN_DEG_Q8;
      end
    end
    pulse = longint'(c.center_pulse_us) + ((angle * longint'(c.gain_q8)) >>> 16);
    if (pulse > PULSE_CEILING) begin
      pulse = PULSE_CEILING;
    end
    r.moving  = 1'b1;
    r.pulse_0 = pulse[PULSE_W-1:0];
    r.pulse_1 = pulse[PULSE_W-1:0];
    r.pulse_2 = pulse[PULSE_W-1:0];
    r.pulse_3 = pulse[PULSE_W-1:0];
    return r;
  endfunction

  // Joystick samples for the random part. Plain uniform bytes dominate; the rest lean on
  // the places where the angle arithmetic is most delicate: near the centre, along the
  // axes, on the diagonals and at the rails.
  function automatic in_word_t random_joystick();
    in_word_t w;
    logic [7:0] a;
    a = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: begin
        w.joy_x = 8'(120 + $urandom_range(0, 16));
        w.joy_y = 8'(120 + $urandom_range(0, 16));
      end
      1: begin
        w.joy_x = a;
        w.joy_y = 8'd128;
      end
      2: begin
        w.joy_x = 8'd128;
        w.joy_y = a;
      end
      3: begin
        w.joy_x = a;
        w.joy_y = $urandom_range(0, 1) ? a : 8'(256 - a);
      end
      4: begin
        w.joy_x = $urandom_range(0, 1) ? 8'd0 : 8'd255;
        w.joy_y = 8'($urandom_range(0, 255));
      end
      default: begin
        w.joy_x = a;
        w.joy_y = 8'($urandom_range(0, 255));
      end
    endcase
    return w;
  endfunction

  // One register write. The handshake is sampled on the rising edge; once it completes the
  // local copy of the settings follows, keeping only the bits the register holds.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEAD_ZONE_SQ: begin
        steer_cfg.dead_zone_sq = val;
        setting_sets++;
      end
      REG_CENTER_PULSE: steer_cfg.center_pulse_us = val[PULSE_W-1:0];
      REG_GAIN_Q8:      steer_cfg.gain_q8 = val;
      REG_STOP_PULSE_0: steer_cfg.stop_pulse[0] = val[PULSE_W-1:0];
      REG_STOP_PULSE_1: steer_cfg.stop_pulse[1] = val[PULSE_W-1:0];
      REG_STOP_PULSE_2: steer_cfg.stop_pulse[2] = val[PULSE_W-1:0];
      REG_STOP_PULSE_3: steer_cfg.stop_pulse[3] = val[PULSE_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every queued word has gone in and every predicted word has come back,
  // then lets the pipeline run empty for its full depth.
  task automatic wait_drained();
    while (joystick_queue.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic offer(input int x, input int y);
    in_word_t w;
    w.joy_x = 8'(x);
    w.joy_y = 8'(y);
    joystick_queue.push_back(w);
  endtask

  // Fresh settings for a random phase. Dead zones are mostly small so that most words
  // steer, with some wide ones; gains often sit at full scale so the ceiling is hit. The
  // centre and stop widths are drawn over the full write width, so bits beyond the
  // register are sent as well and must be dropped.
  task automatic randomise_settings();
    logic [CFG_DATA_W-1:0] dz;
    case ($urandom_range(0, 3))
      0:       dz = '0;
      1:       dz = 16'($urandom_range(0, 200));
      2:       dz = 16'($urandom_range(0, 4000));
      default: dz = 16'($urandom_range(0, 65535));
    endcase
    write_reg(REG_DEAD_ZONE_SQ, dz);
    write_reg(REG_CENTER_PULSE, 16'($urandom_range(0, 65535)));
    write_reg(REG_GAIN_Q8, $urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom_range(0, 65535)));
    write_reg(REG_STOP_PULSE_0, 16'($urandom_range(0, 65535)));
    write_reg(REG_STOP_PULSE_1, 16'($urandom_range(0, 65535)));
    write_reg(REG_STOP_PULSE_2, 16'($urandom_range(0, 65535)));
    write_reg(REG_STOP_PULSE_3, 16'($urandom_range(0, 65535)));
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    end
  endtask

  // Sender. A word is taken from the pending queue only when the input slot is free or
  // is being emptied at this edge, so an offered word never changes before it is taken.
  // The prediction is made at the moment of acceptance, under the settings then in force.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_words.push_back(steer_predict(in_data, steer_cfg));
      end
      if (!in_valid || in_ready) begin
        if (!hold_input && joystick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
          in_valid <= 1'b1;
          in_data  <= joystick_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker. Every servo word taken is held against the oldest prediction,
  // field by field. A long hold-off, once asked for, is counted out here.
  always @(posedge clk) begin : servo_check
    out_word_t want;
    int hold_off_left;
    int hold_off_served;
    if (rst) begin
      out_ready <= 1'b0;
      hold_off_left = 0;
      hold_off_served = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: servo word with nothing outstanding: %s %0b pulses %0d %0d %0d %0d",
                     $realtime, "moving", out_data.moving, out_data.pulse_0, out_data.pulse_1,
                     out_data.pulse_2, out_data.pulse_3);
          end
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (want.moving) begin
            steering_words++;
            if (want.pulse_0 == PULSE_W'(PULSE_CEILING)) begin
              ceiling_words++;
            end
          end else begin
            dead_zone_words++;
          end
          if (out_data.moving !== want.moving || out_data.pulse_0 !== want.pulse_0 ||
              out_data.pulse_1 !== want.pulse_1 || out_data.pulse_2 !== want.pulse_2 ||
              out_data.pulse_3 !== want.pulse_3) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: servo word %0d wrong: expected moving %0b pulses %0d %0d %0d %0d,",
                       $realtime, words_checked, want.moving, want.pulse_0, want.pulse_1,
                       want.pulse_2, want.pulse_3);
              $display("    got moving %0b pulses %0d %0d %0d %0d",
                       out_data.moving, out_data.pulse_0, out_data.pulse_1,
                       out_data.pulse_2, out_data.pulse_3);
            end
          end
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left = hold_off_left - 1;
        out_ready <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
        hold_off_served = hold_off_requests;
        hold_off_left = HOLD_OFF_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: a run that stops moving words on every channel for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d still outstanding", $realtime,
               QUIET_LIMIT, expected_words.size());
      $display("joystick_to_servo_steering regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int p;
    int w;
    steer_cfg.dead_zone_sq    = 16'd0;
    steer_cfg.center_pulse_us = 12'd1500;
    steer_cfg.gain_q8         = 16'd2560;
    steer_cfg.stop_pulse[0]   = 12'd1500;
    steer_cfg.stop_pulse[1]   = 12'd1500;
    steer_cfg.stop_pulse[2]   = 12'd1500;
    steer_cfg.stop_pulse[3]   = 12'd1500;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Settings straight out of reset, with no dead zone: the centred stick still stops,
    // a stick one step right of centre steers at angle zero, both flat directions fold
    // to zero, straight up and straight down give a quarter turn, plus the four corners.
    @(negedge clk);
    offer(128, 128);
    offer(129, 128);
    offer(0, 128);
    offer(255, 128);
    offer(128, 255);
    offer(128, 0);
    offer(255, 255);
    offer(0, 0);
    offer(0, 255);
    offer(255, 0);
    offer(127, 129);
    wait_drained();

    // A dead zone of 100: a deflection of exactly 100 squared stops, 101 steers.
    // The write to the unused index must not disturb anything.
    write_reg(REG_DEAD_ZONE_SQ, 16'd100);
    write_reg(REG_CENTER_PULSE, 16'd1000);
    write_reg(REG_GAIN_Q8, 16'd768);
    write_reg(REG_STOP_PULSE_0, 16'd100);
    write_reg(REG_STOP_PULSE_1, 16'd200);
    write_reg(REG_STOP_PULSE_2, 16'd300);
    write_reg(REG_STOP_PULSE_3, 16'd400);
    write_reg(REG_UNUSED, 16'hFFFF);
    @(negedge clk);
    offer(134, 136);
    offer(138, 129);
    offer(122, 120);
    offer(128, 139);
    wait_drained();

    // Full-scale gain with a centre written with spare upper bits set: a stick pointing
    // straight up runs into the pulse ceiling, while a flat one gives the centre width
    // and a nearly flat one stays a little above it.
    write_reg(REG_DEAD_ZONE_SQ, 16'd0);
    write_reg(REG_CENTER_PULSE, 16'hFBB8);
    write_reg(REG_GAIN_Q8, 16'hFFFF);
    write_reg(REG_STOP_PULSE_0, 16'd0);
    write_reg(REG_STOP_PULSE_1, 16'd4095);
    write_reg(REG_STOP_PULSE_2, 16'd0);
    write_reg(REG_STOP_PULSE_3, 16'd4095);
    @(negedge clk);
    offer(128, 128);
    offer(128, 255);
    offer(129, 128);
    offer(200, 130);
    wait_drained();

    // The widest useful dead zone swallows even the far corner; one step less lets it
    // through, and with zero centre and zero gain the pulse is zero.
    write_reg(REG_DEAD_ZONE_SQ, 16'd32768);
    write_reg(REG_CENTER_PULSE, 16'd0);
    write_reg(REG_GAIN_Q8, 16'd0);
    write_reg(REG_STOP_PULSE_0, 16'd4095);
    write_reg(REG_STOP_PULSE_1, 16'd0);
    write_reg(REG_STOP_PULSE_2, 16'd4095);
    write_reg(REG_STOP_PULSE_3, 16'd0);
    @(negedge clk);
    offer(0, 0);
    offer(255, 255);
    wait_drained();
    write_reg(REG_DEAD_ZONE_SQ, 16'd32767);
    @(negedge clk);
    offer(0, 0);
    wait_drained();

    // Random phases, each with new settings, cycling through the idling patterns:
    // none, a slow sender, a slow receiver, and both a little slow.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      randomise_settings();
      @(negedge clk);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 57;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct = 13;
        end
      endcase
      for (w = 0; w < WORDS_PER_PHASE; w++) begin
        joystick_queue.push_back(random_joystick());
      end
      if (p == 4) begin
        // Back-pressure: the receiver shuts for a long stretch while the sender keeps
        // offering, so the pipeline fills and the input stalls. Later the sender stops
        // until every outstanding word has come back, then carries on.
        hold_off_requests++;
        while (joystick_queue.size() > WORDS_PER_PHASE / 2) @(negedge clk);
        hold_input = 1'b1;
        while (in_valid || expected_words.size() != 0) @(negedge clk);
        hold_input = 1'b0;
      end
      wait_drained();
    end

    $display("Checked %0d servo words over %0d register settings:",
             words_checked, setting_sets);
    $display("%0d steering, %0d in the dead zone, %0d at the pulse ceiling, %0d mismatches.",
             steering_words, dead_zone_words, ceiling_words, mismatches);
    if (mismatches == 0) begin
      $display("joystick_to_servo_steering regression: pass");
    end else begin
      $display("joystick_to_servo_steering regression: fail");
    end
    $finish;
  end

endmodule
